// File: rtl/core/bb3_pkg.sv
package bb3_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned PixW      = 3 * ChanW;
  localparam int unsigned FrameWW   = 11;
  localparam int unsigned FrameHW   = 12;
  localparam int unsigned RowW      = FrameHW + 1;   // row runs up to height+1 while flushing
  localparam int unsigned SumW      = 12;            // 9 * 255 plus rounding bias
  localparam int unsigned DivCntW   = 4;
  localparam int unsigned RecipSh   = 20;
  localparam int unsigned RecipW    = RecipSh + 1;
  localparam int unsigned ProdW     = SumW + RecipW;

  localparam logic [FrameWW-1:0] FrameWidthRst  = 11'd640;
  localparam logic [FrameHW-1:0] FrameHeightRst = 12'd480;

  // register index, taken from paddr[2]
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef logic [PixW-1:0] pix_t;

  // window rows: 0 upper, 1 middle, 2 lower; columns: 0 oldest, 2 newest
  typedef struct packed {
    logic [8:0][PixW-1:0] win;
    logic                 skip_top;
    logic                 skip_bot;
    logic                 skip_left;
    logic                 skip_right;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ceil(2^20 / n): exact floor division for every dividend below 2^12
  function automatic logic [RecipW-1:0] recip(input logic [DivCntW-1:0] n);
    logic [RecipW-1:0] r;
    unique case (n)
      4'd2:    r = 21'd524288;
      4'd3:    r = 21'd349526;
      4'd4:    r = 21'd262144;
      4'd6:    r = 21'd174763;
      4'd9:    r = 21'd116509;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/bb3_queue.sv
module bb3_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bb3_pkg::job_t   push_data_i,
  input  logic            pop_i,
  output bb3_pkg::job_t   head_o,
  output bb3_pkg::q_stat_t stat_o
);
  import bb3_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/core/bb3_front.sv
module bb3_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  logic [$clog2(MAX_WIDTH):0]    width_i,
  input  logic [bb3_pkg::FrameHW-1:0]   height_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [bb3_pkg::ChanW-1:0]     blue_in_i,
  input  logic [bb3_pkg::ChanW-1:0]     green_in_i,
  input  logic [bb3_pkg::ChanW-1:0]     red_in_i,
  input  bb3_pkg::q_stat_t              q_stat_i,
  output logic                          push_o,
  output bb3_pkg::job_t                 job_o
);
  import bb3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // position of the next request
  logic [CW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // decode stage: one request waiting for its line buffer read
  logic            f_valid_q;
  logic [CW-1:0]   f_col_q;
  pix_t            f_pix_q;
  logic            f_ok_q;
  logic            f_top_q, f_bot_q, f_left_q, f_right_q, f_last_q;

  logic [2*PixW-1:0] line_mem [MAX_WIDTH];   // {upper, middle}
  logic [2*PixW-1:0] rd_q;
  logic              byp_q;
  logic [2*PixW-1:0] byp_data_q;
  logic [2*PixW-1:0] f_rd;

  logic [8:0][PixW-1:0] win_q, win_d;
  pix_t                 colv [3];

  logic            accept, flushing, take, f_go;
  pix_t            pix_in;
  logic            res_ok, top, bot, left, right, last;
  logic [RowW-1:0] h_ext;
  logic [CW:0]     col_inc;
  logic            wrap;

  assign h_ext    = {1'b0, height_i};
  assign accept   = in_valid_i && !in_stall_o;
  assign flushing = (row_q >= h_ext);
  assign take     = accept && !(kind_i && !flushing);
  assign pix_in   = flushing ? '0 : {red_in_i, green_in_i, blue_in_i};

  // window centre lies one column back, or at the end of the row before
  always_comb begin
    if (col_q != '0) begin
      res_ok = (row_q != '0) && (row_q <= h_ext);
      top    = (row_q == RowW'(1));
      bot    = (row_q == h_ext);
      left   = (col_q == CW'(1));
      right  = 1'b0;
    end else begin
      res_ok = (row_q >= RowW'(2)) && (row_q <= h_ext + RowW'(1));
      top    = (row_q == RowW'(2));
      bot    = (row_q == h_ext + RowW'(1));
      left   = (width_i == (CW+1)'(1));
      right  = 1'b1;
    end
    last = bot && right;
  end

  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign wrap    = (col_inc >= width_i);

  always_comb begin
    col_d = wrap ? '0 : col_inc[CW-1:0];
    row_d = wrap ? row_q + RowW'(1) : row_q;
    if (res_ok && last) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // a request with no result does not need a queue slot
  assign f_go       = f_valid_q && (!f_ok_q || !q_stat_i.full);
  assign in_stall_o = f_valid_q && f_ok_q && q_stat_i.full;

  assign f_rd    = byp_q ? byp_data_q : rd_q;
  assign colv[0] = f_rd[2*PixW-1:PixW];
  assign colv[1] = f_rd[PixW-1:0];
  assign colv[2] = f_pix_q;

  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3+1];
      win_d[r*3+1]   = win_q[r*3+2];
      win_d[r*3+2]   = colv[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      f_valid_q <= 1'b0;
      win_q     <= '0;
    end else if (restart_i) begin
      col_q     <= '0;
      row_q     <= '0;
      f_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      if (take) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (take) begin
        f_valid_q <= 1'b1;
      end else if (f_go) begin
        f_valid_q <= 1'b0;
      end
      if (f_go) win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      f_col_q   <= col_q;
      f_pix_q   <= pix_in;
      f_ok_q    <= res_ok;
      f_top_q   <= top;
      f_bot_q   <= bot;
      f_left_q  <= left;
      f_right_q <= right;
      f_last_q  <= last;
    end
  end

  // line buffers: read-first, so a same-column write in this edge is forwarded
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q       <= line_mem[col_q];
      byp_q      <= f_go && (f_col_q == col_q);
      byp_data_q <= {colv[1], f_pix_q};
    end
    if (f_go) line_mem[f_col_q] <= {colv[1], f_pix_q};
  end

  assign push_o           = f_go && f_ok_q;
  assign job_o.win        = win_d;
  assign job_o.skip_top   = f_top_q;
  assign job_o.skip_bot   = f_bot_q;
  assign job_o.skip_left  = f_left_q;
  assign job_o.skip_right = f_right_q;
  assign job_o.last       = f_last_q;

endmodule

// File: rtl/core/bb3_back.sv
module bb3_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bb3_pkg::job_t             head_i,
  input  bb3_pkg::q_stat_t          q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bb3_pkg::ChanW-1:0] blue_out_o,
  output logic [bb3_pkg::ChanW-1:0] green_out_o,
  output logic [bb3_pkg::ChanW-1:0] red_out_o,
  output logic                      frame_end_o
);
  import bb3_pkg::*;

  logic                go;
  logic [SumW-1:0]     sum [3];
  logic [1:0]          rows, cols;
  logic [DivCntW-1:0]  n;

  logic                s_valid_q;
  logic [SumW-1:0]     s_sum_q [3];
  logic [DivCntW-1:0]  s_n_q;
  logic                s_last_q;

  logic [RecipW-1:0]   rcp;
  logic [ProdW-1:0]    prod [3];

  logic                out_valid_q;
  logic [ChanW-1:0]    out_q [3];
  logic                out_last_q;

  assign go    = !out_valid_q || !out_stall_i;
  assign pop_o = go && !q_stat_i.empty;

  // masked per-channel sums over the window
  always_comb begin
    logic inc;
    for (int ch = 0; ch < 3; ch++) sum[ch] = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        inc = !((r == 0) && head_i.skip_top) && !((r == 2) && head_i.skip_bot) &&
              !((k == 0) && head_i.skip_left) && !((k == 2) && head_i.skip_right);
        for (int ch = 0; ch < 3; ch++) begin
          if (inc) sum[ch] = sum[ch] + SumW'(head_i.win[r*3+k][ch*ChanW +: ChanW]);
        end
      end
    end
  end

  assign rows = 2'd3 - {1'b0, head_i.skip_top} - {1'b0, head_i.skip_bot};
  assign cols = 2'd3 - {1'b0, head_i.skip_left} - {1'b0, head_i.skip_right};
  assign n    = DivCntW'(rows * cols);

  // round half up: (sum + n/2) / n via reciprocal
  assign rcp = recip(s_n_q);
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = ProdW'(s_sum_q[ch] + SumW'(s_n_q >> 1)) * ProdW'(rcp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (go) begin
      s_valid_q   <= pop_o;
      out_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s_sum_q  <= sum;
      s_n_q    <= n;
      s_last_q <= head_i.last;
    end
    if (go && s_valid_q) begin
      for (int ch = 0; ch < 3; ch++) out_q[ch] <= prod[ch][RecipSh +: ChanW];
      out_last_q <= s_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = out_q[0];
  assign green_out_o = out_q[1];
  assign red_out_o   = out_q[2];
  assign frame_end_o = out_last_q;

endmodule

// File: rtl/core/box_blur_3x3_edge_truncated.sv
// Channel   Dir  Handshake             Payload
// in        in   in_valid_i/in_stall_o  kind_i, blue_in_i, green_in_i, red_in_i
// out       out  out_valid_o/out_stall_i blue_out_o, green_out_o, red_out_o, frame_end_o
// config    in   APB psel/penable       paddr, pwdata, prdata (frame_width @0, frame_height @4)
//
// Sustained rate is one request per cycle while in_stall_o is low; the line buffer
// takes one read and one write per cycle, same-column reuse forwarded.
// A pixel's result leaves width+1 requests later; out_valid_o for that request
// rises after the line buffer read into the window, the queue pop with the sums
// and the reciprocal multiply into the output register; stalls may come between.
// Reset clears position, window, queue and output valid; line buffers are not
// cleared; stale contents reach only window places outside the frame, which are masked.
// out_stall_i backs up the 2-entry queue, then in_stall_o rises.
module box_blur_3x3_edge_truncated #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // request stream
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [bb3_pkg::ChanW-1:0] blue_in_i,
  input  logic [bb3_pkg::ChanW-1:0] green_in_i,
  input  logic [bb3_pkg::ChanW-1:0] red_in_i,
  // result stream
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bb3_pkg::ChanW-1:0] blue_out_o,
  output logic [bb3_pkg::ChanW-1:0] green_out_o,
  output logic [bb3_pkg::ChanW-1:0] red_out_o,
  output logic                      frame_end_o
);
  import bb3_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [FrameWW-1:0] frame_width_q;
  logic [FrameHW-1:0] frame_height_q;
  logic               cfg_wr;
  logic [CW:0]        width_eff;
  logic [FrameHW-1:0] height_eff;

  logic     q_push, q_pop;
  job_t     q_in, q_head;
  q_stat_t  q_stat;

  // ---------------- config registers ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegFrameWidth:  frame_width_q  <= pwdata[FrameWW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[FrameHW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegFrameWidth:  prdata = {{(32-FrameWW){1'b0}}, frame_width_q};
      RegFrameHeight: prdata = {{(32-FrameHW){1'b0}}, frame_height_q};
      default:        prdata = '0;
    endcase
  end

  // width saturates to [1, MAX_WIDTH], height 0 acts as 1
  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(frame_width_q);
    end
    height_eff = (frame_height_q == '0) ? FrameHW'(1) : frame_height_q;
  end

  // ---------------- front: position, line buffers, window ----------------
  bb3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_wr),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .blue_in_i  (blue_in_i),
    .green_in_i (green_in_i),
    .red_in_i   (red_in_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .job_o      (q_in)
  );

  // ---------------- decoupling queue ----------------
  bb3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  // ---------------- back: sums, divide, output register ----------------
  bb3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o),
    .frame_end_o (frame_end_o)
  );

  // ---------------- assertions ----------------
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_stat.full)
    else $error("request stalled while queue has room");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule
